/* sv/oar_pkg.sv */
// Shared types and constants for the octant arc rasteriser.
package oar_pkg;

    localparam int RADIUS_W = 8;
    localparam int MASK_W   = 8;
    localparam int COLOR_W  = 16;
    localparam int ERR_W    = 12;
    localparam int INC_W    = 11;
    localparam int OCT_IDX_W = 3;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // per octant, bit k: horizontal offset taken from y rather than x
    localparam logic [MASK_W-1:0] OCT_SWAP = 8'b0110_0110;
    // per octant, bit k: horizontal offset is subtracted from the centre
    localparam logic [MASK_W-1:0] OCT_HNEG = 8'b0011_1100;
    // per octant, bit k: vertical offset is subtracted from the centre
    localparam logic [MASK_W-1:0] OCT_VNEG = 8'b0000_1111;

    // one iteration's worth of pixels, handed to the emitter
    typedef struct packed {
        logic [RADIUS_W-1:0] x;
        logic [RADIUS_W-1:0] y;
        logic [MASK_W-1:0]   mask;
        logic [COLOR_W-1:0]  color;
        logic                done;
    } t_job;

endpackage

/* sv/oar_emitter.sv */
// Pixel emitter: holds one iteration and sends its enabled octants one per transfer.
module oar_emitter #(
    parameter int COORD_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  oar_pkg::t_job                 i_job,
    input  logic [COORD_BITS-1:0]         i_cx,
    input  logic [COORD_BITS-1:0]         i_cy,
    output logic                          o_free,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [oar_pkg::COLOR_W-1:0]   o_out_color,
    output logic                          o_last_of_step,
    output logic                          o_arc_done
);

    logic [oar_pkg::MASK_W-1:0]    r_rem, n_rem;
    logic [oar_pkg::RADIUS_W-1:0]  r_x, r_y;
    logic [COORD_BITS-1:0]         r_cx, r_cy;
    logic [oar_pkg::COLOR_W-1:0]   r_color;
    logic                          r_done;

    logic [oar_pkg::OCT_IDX_W-1:0] sel;
    logic                          single;
    logic                          xfer;
    logic [COORD_BITS-1:0]         h_off, v_off;

    // lowest enabled octant goes first
    always_comb begin
        sel = '0;
        for (int k = oar_pkg::MASK_W - 1; k >= 0; k--) begin
            if (r_rem[k]) begin
                sel = oar_pkg::OCT_IDX_W'(k);
            end
        end
    end

    assign single = (r_rem & (r_rem - oar_pkg::MASK_W'(1))) == '0;
    assign o_out_valid = r_rem != '0;
    assign xfer = o_out_valid && i_out_ready;
    assign o_free = !o_out_valid || (i_out_ready && single);

    always_comb begin
        if (oar_pkg::OCT_SWAP[sel]) begin
            h_off = COORD_BITS'(r_y);
            v_off = COORD_BITS'(r_x);
        end else begin
            h_off = COORD_BITS'(r_x);
            v_off = COORD_BITS'(r_y);
        end
        o_pixel_x = oar_pkg::OCT_HNEG[sel] ? (r_cx - h_off) : (r_cx + h_off);
        o_pixel_y = oar_pkg::OCT_VNEG[sel] ? (r_cy - v_off) : (r_cy + v_off);
    end

    assign o_out_color    = r_color;
    assign o_last_of_step = single;
    assign o_arc_done     = single && r_done;

    always_comb begin
        if (i_load) begin
            n_rem = i_job.mask;
        end else if (xfer) begin
            n_rem = r_rem & (r_rem - oar_pkg::MASK_W'(1));
        end else begin
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_job.x;
            r_y     <= i_job.y;
            r_cx    <= i_cx;
            r_cy    <= i_cy;
            r_color <= i_job.color;
            r_done  <= i_job.done;
        end
    end

endmodule

/* sv/octant_arc_rasterizer.sv */
// Top level of the midpoint circle and arc pixel generator.
//
//  channel  direction  handshake                  payload
//  in       sink       i_in_valid / o_in_ready    req_type, centre, radius, mask, colour
//  out      source     o_out_valid / i_out_ready  pixel x/y, colour, last_of_step, arc_done
//
// A start transfer latches the arc and emits nothing. A step transfer runs one
// midpoint iteration in the cycle it is accepted and hands its pixels to the
// emitter, which sends one pixel per cycle while i_out_ready is high, one for each
// enabled octant of the mask.
// The next item is taken in the same cycle as the last pixel of the previous one.
// Reset is synchronous, active low; it clears the busy flag and the emitter.
// A stall on the output holds the current pixel and backs up into o_in_ready.
module octant_arc_rasterizer #(
    parameter int COORD_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [COORD_BITS-1:0]         i_center_x,
    input  logic [COORD_BITS-1:0]         i_center_y,
    input  logic [oar_pkg::RADIUS_W-1:0]  i_radius,
    input  logic [oar_pkg::MASK_W-1:0]    i_octant_mask,
    input  logic [oar_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [oar_pkg::COLOR_W-1:0]   o_out_color,
    output logic                          o_last_of_step,
    output logic                          o_arc_done
);

    // arc state
    logic                                r_busy, n_busy;
    logic [COORD_BITS-1:0]               r_cx, r_cy;
    logic [oar_pkg::MASK_W-1:0]          r_mask;
    logic [oar_pkg::COLOR_W-1:0]         r_color;
    logic [oar_pkg::RADIUS_W-1:0]        r_x, n_x;
    logic [oar_pkg::RADIUS_W-1:0]        r_y;
    logic signed [oar_pkg::ERR_W-1:0]    r_err, n_err, err_y;
    logic signed [oar_pkg::INC_W-1:0]    r_xinc, n_xinc;
    logic signed [oar_pkg::INC_W-1:0]    r_yinc;
    logic signed [oar_pkg::ERR_W+1:0]    mid_test;
    logic [oar_pkg::RADIUS_W:0]          y_next;

    logic          accept;
    logic          do_start;
    logic          do_step;
    logic          emit_free;
    oar_pkg::t_job job;

    assign o_in_ready = emit_free;
    assign accept     = i_in_valid && o_in_ready;
    // a start with zero radius or empty mask leaves everything alone
    assign do_start   = accept && (i_req_type == oar_pkg::REQ_START)
                        && (i_radius != '0) && (i_octant_mask != '0);
    // a step while idle is dropped
    assign do_step    = accept && (i_req_type == oar_pkg::REQ_STEP) && r_busy;

    // one midpoint iteration: advance y, add the y increment, then test the midpoint
    always_comb begin
        y_next   = {1'b0, r_y} + (oar_pkg::RADIUS_W + 1)'(1);
        err_y    = r_err + oar_pkg::ERR_W'(r_yinc);
        mid_test = signed'({err_y[oar_pkg::ERR_W-1], err_y, 1'b0})
                   + (oar_pkg::ERR_W + 2)'(r_xinc);
        if (!mid_test[oar_pkg::ERR_W+1] && (mid_test != '0)) begin
            // step x inward
            n_x    = r_x - oar_pkg::RADIUS_W'(1);
            n_err  = err_y + oar_pkg::ERR_W'(r_xinc);
            n_xinc = r_xinc + oar_pkg::INC_W'(2);
        end else begin
            n_x    = r_x;
            n_err  = err_y;
            n_xinc = r_xinc;
        end
        // arc ends once x falls below y
        n_busy = !({1'b0, n_x} < y_next);
    end

    // pixels use the position before the update
    always_comb begin
        job.x     = r_x;
        job.y     = r_y;
        job.mask  = r_mask;
        job.color = r_color;
        job.done  = !n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (do_start) begin
            r_busy <= 1'b1;
        end else if (do_step) begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_mask  <= i_octant_mask;
            r_color <= i_pixel_color;
            r_x     <= i_radius;
            r_y     <= '0;
            r_err   <= '0;
            r_xinc  <= signed'(oar_pkg::INC_W'(1) - {2'b00, i_radius, 1'b0});
            r_yinc  <= '0;
        end else if (do_step) begin
            r_x     <= n_x;
            r_y     <= y_next[oar_pkg::RADIUS_W-1:0];
            r_err   <= n_err;
            r_xinc  <= n_xinc;
            r_yinc  <= r_yinc + oar_pkg::INC_W'(2);
        end
    end

    oar_emitter #(
        .COORD_BITS (COORD_BITS)
    ) u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (do_step),
        .i_job          (job),
        .i_cx           (r_cx),
        .i_cy           (r_cy),
        .o_free         (emit_free),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_out_color    (o_out_color),
        .o_last_of_step (o_last_of_step),
        .o_arc_done     (o_arc_done)
    );

endmodule
